// File: src/assert_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, disabled while reset is held.
`define RTCPP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rtcp parser assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define RTCPP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rtcp parser implication failed");

`endif

// File: src/rtcpp_pkg.sv
// Shared types and constants of the RTCP compound packet parser.
package rtcpp_pkg;

  // Counter and offset sizing
  localparam int unsigned INDEX_BITS  = 8;
  localparam int unsigned OFFSET_BITS = 20;
  localparam int unsigned INDEX_MAX   = (1 << INDEX_BITS) - 1;

  // Record queue sizing
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Record kinds
  localparam logic [4:0] KIND_HEADER    = 5'd0;
  localparam logic [4:0] KIND_SSRC      = 5'd1;
  localparam logic [4:0] KIND_BLK_SSRC  = 5'd7;
  localparam logic [4:0] KIND_FRAC_LOST = 5'd8;
  localparam logic [4:0] KIND_CUM_LOST  = 5'd9;
  localparam logic [4:0] KIND_HIGH_SEQ  = 5'd10;
  localparam logic [4:0] KIND_JITTER    = 5'd11;
  localparam logic [4:0] KIND_LSR       = 5'd12;
  localparam logic [4:0] KIND_DLSR      = 5'd13;
  localparam logic [4:0] KIND_SDES_ITEM = 5'd14;
  localparam logic [4:0] KIND_SDES_TEXT = 5'd15;
  localparam logic [4:0] KIND_BYE_SRC   = 5'd16;
  localparam logic [4:0] KIND_REJECT    = 5'd17;

  // Packet types
  localparam logic [7:0] PT_SR   = 8'd200;
  localparam logic [7:0] PT_RR   = 8'd201;
  localparam logic [7:0] PT_SDES = 8'd202;
  localparam logic [7:0] PT_BYE  = 8'd203;

  // One output record
  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  pkt_idx;
    logic [7:0]  item_idx;
    logic [31:0] value;
    logic [1:0]  version;
    logic        padding;
    logic [4:0]  rcount;
    logic [7:0]  ptype;
    logic [7:0]  sdes_type;
    logic        last;
  } record_t;

  // Record queue status
  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
    logic                  room2;
  } fifo_status_t;

endpackage

// File: src/rtcpp_rec_fifo.sv
// Record queue: takes up to two records per cycle, delivers one per cycle while pop_i is high.
module rtcpp_rec_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             wr_cnt_i,
  input  rtcpp_pkg::record_t     rec0_i,
  input  rtcpp_pkg::record_t     rec1_i,
  input  logic                   pop_i,
  output rtcpp_pkg::record_t     head_o,
  output logic                   valid_o,
  output rtcpp_pkg::fifo_status_t status_o
);

  rtcpp_pkg::record_t mem_q [rtcpp_pkg::FIFO_DEPTH];

  logic [rtcpp_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_nx;
  logic [rtcpp_pkg::FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [rtcpp_pkg::FIFO_CNT_W-1:0] count_q, count_d;
  logic                             pop;

  // Advance pointers and occupancy
  always_comb begin
    pop       = pop_i && (count_q != '0);
    wr_ptr_nx = rtcpp_pkg::FIFO_PTR_W'(wr_ptr_q + 1'b1);
    wr_ptr_d  = rtcpp_pkg::FIFO_PTR_W'(wr_ptr_q + wr_cnt_i);
    rd_ptr_d  = pop ? rtcpp_pkg::FIFO_PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d   = rtcpp_pkg::FIFO_CNT_W'(count_q + rtcpp_pkg::FIFO_CNT_W'(wr_cnt_i)
                - rtcpp_pkg::FIFO_CNT_W'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store incoming records
  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= rec0_i;
    end
    if (wr_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= rec1_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign valid_o        = (count_q != '0);
  assign status_o.count = count_q;
  assign status_o.room2 = (count_q <= rtcpp_pkg::FIFO_CNT_W'(rtcpp_pkg::FIFO_DEPTH - 2));

endmodule

// File: src/rtcp_compound_packet_parser.sv
// Output: the records of an accepted byte are written into the record queue, whose head drives the output.
// Throughput: one datagram byte per cycle while tready is high; a byte that yields two records
// (field plus reject at datagram end) writes both into a four-entry record queue, which
// drops tready when fewer than two slots are free.
// Reset: rst_ni is asynchronous, active low; it clears the parser state and the queue.
`include "assert_macros.svh"

module rtcp_compound_packet_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_datagram
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] packet_index, [15:8] item_index, [47:16] field_value,
  // [49:48] rtcp_version, [50] padding_flag, [55:51] report_count,
  // [63:56] packet_type, [71:64] sdes_type
  output logic [71:0] m_axis_tdata_o,
  output logic [4:0]  m_axis_tuser_o,   // [4:0] record_kind
  output logic        m_axis_tlast_o    // last_of_run
);

  localparam int unsigned IB = rtcpp_pkg::INDEX_BITS;
  localparam int unsigned OB = rtcpp_pkg::OFFSET_BITS;

  typedef enum logic [3:0] {
    PH_HDR, PH_SR, PH_RR, PH_SDES_SRC, PH_SDES_TYPE,
    PH_SDES_LEN, PH_SDES_TEXT, PH_BYE, PH_SKIP
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [17:0] bip_q, bip_d;
  logic [15:0] len_q, len_d;
  logic [31:0] fs_q, fs_d;
  logic [15:0] hdr_q, hdr_d;
  logic [IB-1:0] pkt_q, pkt_d;
  logic [IB-1:0] item_q, item_d;
  logic [7:0]  left_q, left_d;
  logic [4:0]  sub_q, sub_d;
  logic [OB-1:0] dgoff_q, dgoff_d;
  logic [OB-1:0] pso_q, pso_d;
  logic        rej_q, rej_d;

  logic        in_beat;
  logic [7:0]  b;
  logic [17:0] p;
  logic [18:0] bip_inc;
  logic [15:0] len_new;
  logic [2:0]  m3_sum;
  logic [1:0]  len_m3;
  logic        len_ok;
  logic [31:0] acc_v;
  logic [4:0]  kind;
  logic [4:0]  bye_w;
  logic [7:0]  bye8;
  logic        rec0_v, rec1_v;
  rtcpp_pkg::record_t rec0, rec1, rec_a, rec_b;
  logic [1:0]  wr_cnt;

  rtcpp_pkg::record_t      head;
  logic                    head_v;
  rtcpp_pkg::fifo_status_t fifo_st;

  // Residue of a byte modulo three from its base-four digits
  function automatic logic [1:0] mod3_byte(input logic [7:0] v);
    logic [3:0] s;
    logic [1:0] r;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
      4'd2, 4'd5, 4'd8, 4'd11:       r = 2'd2;
      default:                       r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [IB-1:0] sat_inc(input logic [IB-1:0] v);
    return (v == '1) ? v : IB'(v + 1'b1);
  endfunction

  function automatic rtcpp_pkg::record_t make_rec(input logic [4:0] k, input logic [7:0] pi,
                                                  input logic [7:0] ii, input logic [31:0] val,
                                                  input logic [7:0] sdt);
    rtcpp_pkg::record_t r;
    r           = '0;
    r.kind      = k;
    r.pkt_idx   = pi;
    r.item_idx  = ii;
    r.value     = val;
    r.sdes_type = sdt;
    return r;
  endfunction

  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = fifo_st.room2;

  // Parse one byte
  always_comb begin
    b       = s_axis_tdata_i;
    p       = 18'(bip_q - 18'd4);
    bip_inc = 19'(bip_q) + 19'd1;
    len_new = {len_q[15:8], b};
    m3_sum  = 3'(mod3_byte(len_q[15:8])) + 3'(mod3_byte(b));
    len_m3  = (m3_sum >= 3'd3) ? 2'(m3_sum - 3'd3) : m3_sum[1:0];
    if (hdr_q[7:0] == rtcpp_pkg::PT_SR) begin
      len_ok = !len_new[0] && (len_m3 == 2'd0) && (len_new != '0);
    end else if (hdr_q[7:0] == rtcpp_pkg::PT_RR) begin
      len_ok = len_new[0] && (len_m3 == 2'd1);
    end else begin
      len_ok = 1'b1;
    end
    acc_v = {fs_q[23:0], b};
    bye_w = p[6:2];
    bye8  = (int'(bye_w) > int'(rtcpp_pkg::INDEX_MAX)) ? 8'(rtcpp_pkg::INDEX_MAX) : 8'(bye_w);
    kind  = rtcpp_pkg::KIND_HEADER;

    phase_d = phase_q;
    bip_d   = bip_q;
    len_d   = len_q;
    fs_d    = fs_q;
    hdr_d   = hdr_q;
    pkt_d   = pkt_q;
    item_d  = item_q;
    left_d  = left_q;
    sub_d   = sub_q;
    dgoff_d = dgoff_q;
    pso_d   = pso_q;
    rej_d   = rej_q;
    rec0_v  = 1'b0;
    rec1_v  = 1'b0;
    rec0    = '0;
    rec1    = '0;

    if (in_beat) begin
      if (!rej_q) begin
        if (phase_q == PH_HDR) begin
          // Collect the four header bytes, open the packet on the last
          case (bip_q[1:0])
            2'd0: begin
              hdr_d = {b, 8'd0};
              pso_d = dgoff_q;
            end
            2'd1: hdr_d = {hdr_q[15:8], b};
            2'd2: len_d = {b, 8'd0};
            default: begin
              len_d  = len_new;
              rec0_v = 1'b1;
              if (!len_ok) begin
                // Bad report length: reject in place of the header
                rej_d = 1'b1;
                rec0  = make_rec(rtcpp_pkg::KIND_REJECT, 8'(pkt_q), 8'd0,
                                 32'(pso_q), 8'd0);
              end else begin
                rec0         = make_rec(rtcpp_pkg::KIND_HEADER, 8'(pkt_q), 8'd0,
                                        32'(len_new), 8'd0);
                rec0.version = hdr_q[15:14];
                rec0.padding = hdr_q[13];
                rec0.rcount  = hdr_q[12:8];
                rec0.ptype   = hdr_q[7:0];
                fs_d   = '0;
                item_d = '0;
                left_d = '0;
                sub_d  = '0;
                if (hdr_q[7:0] == rtcpp_pkg::PT_SR) begin
                  phase_d = PH_SR;
                end else if (hdr_q[7:0] == rtcpp_pkg::PT_RR) begin
                  phase_d = PH_RR;
                end else if (hdr_q[7:0] == rtcpp_pkg::PT_SDES) begin
                  phase_d = PH_SDES_SRC;
                end else if (hdr_q[7:0] == rtcpp_pkg::PT_BYE) begin
                  phase_d = PH_BYE;
                end else begin
                  phase_d = PH_SKIP;
                end
              end
            end
          endcase
        end else begin
          case (phase_q)
            PH_SR, PH_RR: begin
              fs_d = acc_v;
              if ((phase_q == PH_SR) ? (p < 18'd24) : (p < 18'd4)) begin
                // Sender SSRC and sender info words
                if (p[1:0] == 2'b11) begin
                  kind   = (phase_q == PH_SR) ? 5'(rtcpp_pkg::KIND_SSRC + 5'(p[4:2]))
                                              : rtcpp_pkg::KIND_SSRC;
                  fs_d   = '0;
                  rec0_v = 1'b1;
                  rec0   = make_rec(kind, 8'(pkt_q), 8'd0, acc_v, 8'd0);
                end
              end else begin
                // Report block fields by position within the 24-byte block
                case (sub_q)
                  5'd3:    kind = rtcpp_pkg::KIND_BLK_SSRC;
                  5'd4:    kind = rtcpp_pkg::KIND_FRAC_LOST;
                  5'd7:    kind = rtcpp_pkg::KIND_CUM_LOST;
                  5'd11:   kind = rtcpp_pkg::KIND_HIGH_SEQ;
                  5'd15:   kind = rtcpp_pkg::KIND_JITTER;
                  5'd19:   kind = rtcpp_pkg::KIND_LSR;
                  5'd23:   kind = rtcpp_pkg::KIND_DLSR;
                  default: kind = rtcpp_pkg::KIND_HEADER;
                endcase
                if (kind != rtcpp_pkg::KIND_HEADER) begin
                  fs_d   = '0;
                  rec0_v = 1'b1;
                  rec0   = make_rec(kind, 8'(pkt_q), 8'(item_q), acc_v, 8'd0);
                end
                if (sub_q == 5'd23) begin
                  sub_d  = '0;
                  item_d = sat_inc(item_q);
                end else begin
                  sub_d = 5'(sub_q + 5'd1);
                end
              end
            end
            PH_SDES_SRC: begin
              fs_d = acc_v;
              if (p == 18'd3) begin
                rec0_v  = 1'b1;
                rec0    = make_rec(rtcpp_pkg::KIND_SSRC, 8'(pkt_q), 8'd0, acc_v, 8'd0);
                fs_d    = '0;
                phase_d = PH_SDES_TYPE;
              end
            end
            PH_SDES_TYPE: begin
              if (b == 8'd0) begin
                phase_d = PH_SKIP;
                rec0_v  = 1'b1;
                rec0    = make_rec(rtcpp_pkg::KIND_SDES_ITEM, 8'(pkt_q), 8'(item_q),
                                   32'd0, 8'd0);
              end else begin
                fs_d    = 32'(b);
                phase_d = PH_SDES_LEN;
              end
            end
            PH_SDES_LEN: begin
              rec0_v = 1'b1;
              rec0   = make_rec(rtcpp_pkg::KIND_SDES_ITEM, 8'(pkt_q), 8'(item_q),
                                32'(b), fs_q[7:0]);
              left_d = b;
              if (b == 8'd0) begin
                item_d  = sat_inc(item_q);
                phase_d = PH_SDES_TYPE;
              end else begin
                phase_d = PH_SDES_TEXT;
              end
            end
            PH_SDES_TEXT: begin
              rec0_v = 1'b1;
              rec0   = make_rec(rtcpp_pkg::KIND_SDES_TEXT, 8'(pkt_q), 8'(item_q),
                                32'(b), fs_q[7:0]);
              left_d = 8'(left_q - 8'd1);
              if (left_d == 8'd0) begin
                item_d  = sat_inc(item_q);
                phase_d = PH_SDES_TYPE;
              end
            end
            PH_BYE: begin
              // Only the first report_count words are sources
              if (p[17:2] < 16'(hdr_q[12:8])) begin
                fs_d = acc_v;
                if (p[1:0] == 2'b11) begin
                  rec0_v = 1'b1;
                  rec0   = make_rec(rtcpp_pkg::KIND_BYE_SRC, 8'(pkt_q), bye8, acc_v, 8'd0);
                  fs_d   = '0;
                end
              end
            end
            default: ;
          endcase
        end

        // Close the packet once its length is consumed
        if (!rej_d) begin
          if (bip_inc >= 19'd4 && bip_inc == {17'(len_d) + 17'd1, 2'b00}) begin
            phase_d = PH_HDR;
            bip_d   = '0;
            pkt_d   = sat_inc(pkt_q);
          end else begin
            bip_d = bip_inc[17:0];
          end
        end
      end

      // Datagram end: flag a cut packet, then drop all per-datagram state
      if (s_axis_tlast_i) begin
        if (!rej_d && (phase_d != PH_HDR || bip_d != '0)) begin
          rec1_v = 1'b1;
          rec1   = make_rec(rtcpp_pkg::KIND_REJECT, 8'(pkt_q), 8'd0, 32'(pso_d), 8'd0);
        end
        phase_d = PH_HDR;
        bip_d   = '0;
        len_d   = '0;
        fs_d    = '0;
        hdr_d   = '0;
        pkt_d   = '0;
        item_d  = '0;
        left_d  = '0;
        sub_d   = '0;
        dgoff_d = '0;
        pso_d   = '0;
        rej_d   = 1'b0;
      end else if (dgoff_q != '1) begin
        dgoff_d = OB'(dgoff_q + 1'b1);
      end
    end

    // Order records into the queue and mark the last one
    rec_a = rec0_v ? rec0 : rec1;
    rec_b = rec1;
    wr_cnt = 2'(rec0_v) + 2'(rec1_v);
    rec_a.last = !(rec0_v && rec1_v);
    rec_b.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      bip_q   <= '0;
      len_q   <= '0;
      fs_q    <= '0;
      hdr_q   <= '0;
      pkt_q   <= '0;
      item_q  <= '0;
      left_q  <= '0;
      sub_q   <= '0;
      dgoff_q <= '0;
      pso_q   <= '0;
      rej_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      bip_q   <= bip_d;
      len_q   <= len_d;
      fs_q    <= fs_d;
      hdr_q   <= hdr_d;
      pkt_q   <= pkt_d;
      item_q  <= item_d;
      left_q  <= left_d;
      sub_q   <= sub_d;
      dgoff_q <= dgoff_d;
      pso_q   <= pso_d;
      rej_q   <= rej_d;
    end
  end

  rtcpp_rec_fifo u_rec_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_cnt_i (wr_cnt),
    .rec0_i   (rec_a),
    .rec1_i   (rec_b),
    .pop_i    (m_axis_tready_i),
    .head_o   (head),
    .valid_o  (head_v),
    .status_o (fifo_st)
  );

  // Drive the output beat from the queue head
  assign m_axis_tvalid_o = head_v;
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = head.last;
  assign m_axis_tdata_o  = {head.sdes_type, head.ptype, head.rcount, head.padding,
                            head.version, head.value, head.item_idx, head.pkt_idx};

  // A latched reject freezes the parser just after the fourth header byte
  `RTCPP_ASSERT_IMPL(a_rej_frozen, rej_q, (phase_q == PH_HDR && bip_q == 18'd3))
  // A datagram end returns the parser to its idle state
  `RTCPP_ASSERT(a_eod_clears, (in_beat && s_axis_tlast_i) |=>
                (phase_q == PH_HDR && bip_q == '0 && !rej_q && dgoff_q == '0))
  // The queue never holds more than its depth
  `RTCPP_ASSERT(a_fifo_bound, fifo_st.count <= rtcpp_pkg::FIFO_CNT_W'(rtcpp_pkg::FIFO_DEPTH))

endmodule

// File: tb/rtcp_compound_packet_parser_tb.sv
// Self-checking testbench for the RTCP compound packet parser.
module rtcp_compound_packet_parser_tb;

  localparam int unsigned CYCLE_LIMIT      = 500000;
  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned SETTLE_CYCLES    = 20;
  localparam int unsigned RANDOM_PER_PHASE = 250;
  localparam int unsigned SHOW_LIMIT       = 10;
  localparam int unsigned OFFSET_MAX       = (1 << rtcpp_pkg::OFFSET_BITS) - 1;
  localparam logic [7:0]  PT_APP           = 8'd204;
  localparam logic [7:0]  SDES_END         = 8'd0;

  // Parser position inside a packet
  typedef enum logic [3:0] {
    ST_HEADER,
    ST_SR_BODY,
    ST_RR_BODY,
    ST_SDES_SSRC,
    ST_SDES_TYPE,
    ST_SDES_LEN,
    ST_SDES_TEXT,
    ST_BYE_BODY,
    ST_SKIP
  } parse_state_e;

  // One byte beat waiting for the driver, with the pacing that applies to it
  typedef struct {
    logic [7:0]  data;
    logic        eod;
    int unsigned gap_pct;
    int unsigned stall_pct;
    bit          hold;
    bit          drain;
  } beat_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic [4:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  rtcp_compound_packet_parser DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stimulus and pacing
  beat_t       beat_q[$];
  logic [7:0]  dgram[$];
  int unsigned plan_gap   = 0;
  int unsigned plan_stall = 0;
  bit          mark_hold  = 1'b0;
  bit          mark_drain = 1'b0;
  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  bit          hold_req   = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  // Parser state mirrored by the prediction
  parse_state_e         phase;
  int unsigned          pkt_byte;
  logic [15:0]          len_words;
  logic [31:0]          shift_acc;
  logic [15:0]          hdr_word;
  int unsigned          pkt_num;
  int unsigned          item_num;
  logic [7:0]           text_left;
  logic [rtcpp_pkg::OFFSET_BITS-1:0] dgram_off;
  logic [rtcpp_pkg::OFFSET_BITS-1:0] pkt_start;
  bit                   rejected;
  rtcpp_pkg::record_t   byte_recs[$];
  rtcpp_pkg::record_t   want_records[$];

  function automatic int unsigned clamp_index(int unsigned v);
    return (v > rtcpp_pkg::INDEX_MAX) ? rtcpp_pkg::INDEX_MAX : v;
  endfunction

  function automatic void restart_datagram();
    phase     = ST_HEADER;
    pkt_byte  = 0;
    len_words = '0;
    shift_acc = '0;
    hdr_word  = '0;
    pkt_num   = 0;
    item_num  = 0;
    text_left = '0;
    dgram_off = '0;
    pkt_start = '0;
    rejected  = 1'b0;
  endfunction

  function automatic void emit(logic [4:0] kind, int unsigned item, logic [31:0] value,
                               logic [7:0] sdt);
    rtcpp_pkg::record_t r;
    r           = '0;
    r.kind      = kind;
    r.pkt_idx   = 8'(pkt_num);
    r.item_idx  = 8'(clamp_index(item));
    r.value     = value;
    r.sdes_type = sdt;
    byte_recs.push_back(r);
  endfunction

  // Check the length, emit the header or a reject, and pick the body parser
  function automatic void open_packet();
    logic [7:0]         pt;
    bit                 ok;
    rtcpp_pkg::record_t r;
    pt = hdr_word[7:0];
    ok = 1'b1;
    if (pt == rtcpp_pkg::PT_SR) ok = len_words >= 6 && len_words % 6 == 0;
    if (pt == rtcpp_pkg::PT_RR) ok = len_words >= 1 && (len_words - 16'd1) % 6 == 0;
    if (!ok) begin
      rejected = 1'b1;
      emit(rtcpp_pkg::KIND_REJECT, 0, 32'(pkt_start), 8'h00);
      return;
    end
    r         = '0;
    r.kind    = rtcpp_pkg::KIND_HEADER;
    r.pkt_idx = 8'(pkt_num);
    r.value   = 32'(len_words);
    r.version = hdr_word[15:14];
    r.padding = hdr_word[13];
    r.rcount  = hdr_word[12:8];
    r.ptype   = pt;
    byte_recs.push_back(r);
    shift_acc = '0;
    item_num  = 0;
    text_left = '0;
    case (pt)
      rtcpp_pkg::PT_SR:   phase = ST_SR_BODY;
      rtcpp_pkg::PT_RR:   phase = ST_RR_BODY;
      rtcpp_pkg::PT_SDES: phase = ST_SDES_SSRC;
      rtcpp_pkg::PT_BYE:  phase = ST_BYE_BODY;
      default:            phase = ST_SKIP;
    endcase
  endfunction

  // Shift a sender/receiver report byte in and emit each completed field
  function automatic void report_field(int unsigned p, logic [7:0] b, bit is_sr);
    logic [31:0] acc;
    int unsigned q;
    logic [4:0]  kind;
    acc       = {shift_acc[23:0], b};
    shift_acc = acc;
    if (is_sr && p < 24) begin
      // sender SSRC, then the five sender info words
      if (p % 4 == 3) begin
        shift_acc = '0;
        emit(5'(rtcpp_pkg::KIND_SSRC + p / 4), 0, acc, 8'h00);
      end
      return;
    end
    if (!is_sr && p < 4) begin
      if (p == 3) begin
        shift_acc = '0;
        emit(rtcpp_pkg::KIND_SSRC, 0, acc, 8'h00);
      end
      return;
    end
    q    = p - (is_sr ? 24 : 4);
    kind = rtcpp_pkg::KIND_HEADER;
    // last byte of each field inside a 24-byte report block
    case (q % 24)
      3:       kind = rtcpp_pkg::KIND_BLK_SSRC;
      4:       kind = rtcpp_pkg::KIND_FRAC_LOST;
      7:       kind = rtcpp_pkg::KIND_CUM_LOST;
      11:      kind = rtcpp_pkg::KIND_HIGH_SEQ;
      15:      kind = rtcpp_pkg::KIND_JITTER;
      19:      kind = rtcpp_pkg::KIND_LSR;
      23:      kind = rtcpp_pkg::KIND_DLSR;
      default: kind = rtcpp_pkg::KIND_HEADER;
    endcase
    if (kind != rtcpp_pkg::KIND_HEADER) begin
      shift_acc = '0;
      emit(kind, q / 24, acc, 8'h00);
    end
  endfunction

  function automatic void body_byte(int unsigned p, logic [7:0] b);
    case (phase)
      ST_SR_BODY: report_field(p, b, 1'b1);
      ST_RR_BODY: report_field(p, b, 1'b0);
      ST_SDES_SSRC: begin
        shift_acc = {shift_acc[23:0], b};
        if (p == 3) begin
          emit(rtcpp_pkg::KIND_SSRC, 0, shift_acc, 8'h00);
          shift_acc = '0;
          phase     = ST_SDES_TYPE;
        end
      end
      ST_SDES_TYPE: begin
        if (b == SDES_END) begin
          phase = ST_SKIP;
          emit(rtcpp_pkg::KIND_SDES_ITEM, item_num, '0, 8'h00);
        end else begin
          shift_acc = {24'h0, b};
          phase     = ST_SDES_LEN;
        end
      end
      ST_SDES_LEN: begin
        emit(rtcpp_pkg::KIND_SDES_ITEM, item_num, {24'h0, b}, shift_acc[7:0]);
        text_left = b;
        if (b == 8'h00) begin
          item_num = clamp_index(item_num + 1);
          phase    = ST_SDES_TYPE;
        end else begin
          phase = ST_SDES_TEXT;
        end
      end
      ST_SDES_TEXT: begin
        emit(rtcpp_pkg::KIND_SDES_TEXT, item_num, {24'h0, b}, shift_acc[7:0]);
        text_left = text_left - 8'd1;
        if (text_left == 8'h00) begin
          item_num = clamp_index(item_num + 1);
          phase    = ST_SDES_TYPE;
        end
      end
      ST_BYE_BODY: begin
        // only the first report-count words are sources
        if ((p >> 2) < 32'(hdr_word[12:8])) begin
          shift_acc = {shift_acc[23:0], b};
          if (p % 4 == 3) begin
            emit(rtcpp_pkg::KIND_BYE_SRC, p >> 2, shift_acc, 8'h00);
            shift_acc = '0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Advance the mirrored parser by one byte and queue the records it causes
  function automatic void parse_byte(logic [7:0] b, logic eod);
    int unsigned        pos;
    rtcpp_pkg::record_t r;
    byte_recs.delete();
    if (!rejected) begin
      pos = pkt_byte;
      if (phase == ST_HEADER) begin
        case (pos)
          0: begin
            hdr_word  = {b, 8'h00};
            pkt_start = dgram_off;
          end
          1: hdr_word[7:0] = b;
          2: len_words = {b, 8'h00};
          default: begin
            len_words[7:0] = b;
            open_packet();
          end
        endcase
      end else begin
        body_byte(pos - 4, b);
      end
      if (!rejected) begin
        pos++;
        if (pos >= 4 && pos == (32'(len_words) + 1) * 4) begin
          phase   = ST_HEADER;
          pos     = 0;
          pkt_num = clamp_index(pkt_num + 1);
        end
        pkt_byte = pos;
      end
    end
    if (eod) begin
      // datagram cut inside a packet
      if (!rejected && (phase != ST_HEADER || pkt_byte != 0))
        emit(rtcpp_pkg::KIND_REJECT, 0, 32'(pkt_start), 8'h00);
      restart_datagram();
    end else if (dgram_off < OFFSET_MAX) begin
      dgram_off++;
    end
    if (byte_recs.size() != 0) begin
      r      = byte_recs.pop_back();
      r.last = 1'b1;
      byte_recs.push_back(r);
    end
    foreach (byte_recs[i]) want_records.push_back(byte_recs[i]);
  endfunction

  function automatic string show_record(rtcpp_pkg::record_t r);
    return $sformatf({"kind=%0d pkt=%0d item=%0d value=%h ver=%0d pad=%0d ",
                      "cnt=%0d pt=%0d sdes=%0d last=%0d"},
                     r.kind, r.pkt_idx, r.item_idx, r.value, r.version, r.padding,
                     r.rcount, r.ptype, r.sdes_type, r.last);
  endfunction

  // Datagram construction
  function automatic void add_random(int unsigned n);
    repeat (n) dgram.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void add_header(logic [1:0] ver, logic pad, logic [4:0] cnt,
                                     logic [7:0] pt, int unsigned words);
    dgram.push_back({ver, pad, cnt});
    dgram.push_back(pt);
    dgram.push_back(8'(words >> 8));
    dgram.push_back(8'(words));
  endfunction

  function automatic logic [1:0] pick_version();
    return ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : 2'd2;
  endfunction

  function automatic void send_datagram();
    beat_t bt;
    for (int i = 0; i < dgram.size(); i++) begin
      bt.data      = dgram[i];
      bt.eod       = (i == dgram.size() - 1);
      bt.gap_pct   = plan_gap;
      bt.stall_pct = plan_stall;
      bt.hold      = mark_hold && i == 0;
      bt.drain     = mark_drain && i == 0;
      beat_q.push_back(bt);
    end
    if (dgram.size() != 0) begin
      mark_hold  = 1'b0;
      mark_drain = 1'b0;
    end
    dgram.delete();
  endfunction

  // Build one SDES chunk; many_items drives the item index into saturation
  function automatic void add_sdes(bit many_items);
    logic [7:0]  chunk[$];
    int unsigned n_items;
    int unsigned tlen;
    int unsigned words;
    repeat (4) chunk.push_back(8'($urandom_range(255)));
    n_items = many_items ? 260 : $urandom_range(4);
    repeat (n_items) begin
      if (many_items) tlen = 0;
      else if ($urandom_range(29) == 0) tlen = $urandom_range(200, 255);
      else if ($urandom_range(2) == 0) tlen = 0;
      else tlen = $urandom_range(1, 10);
      chunk.push_back(8'($urandom_range(1, 255)));
      chunk.push_back(8'(tlen));
      repeat (tlen) chunk.push_back(8'($urandom_range(255)));
    end
    if (many_items || $urandom_range(3) != 0) chunk.push_back(SDES_END);
    while (chunk.size() % 4 != 0) chunk.push_back(8'h00);
    words = chunk.size() / 4;
    // sometimes the packet length cuts the chunk short
    if (!many_items && $urandom_range(5) == 0) words = $urandom_range(words);
    add_header(pick_version(), 1'($urandom_range(1)), 5'($urandom_range(31)),
               rtcpp_pkg::PT_SDES, words);
    for (int i = 0; i < words * 4; i++) dgram.push_back(chunk[i]);
  endfunction

  function automatic void add_random_packet();
    int unsigned pick;
    int unsigned nb;
    int unsigned w;
    int unsigned rc;
    logic [7:0]  pt;
    pick = $urandom_range(8);
    nb   = $urandom_range(3);
    // weighted choice of packet type
    case (pick)
      0, 1: begin
        add_header(pick_version(), 1'($urandom_range(1)), 5'($urandom_range(31)),
                   rtcpp_pkg::PT_SR, 6 + 6 * nb);
        add_random(24 + 24 * nb);
      end
      2, 3: begin
        add_header(pick_version(), 1'($urandom_range(1)), 5'($urandom_range(31)),
                   rtcpp_pkg::PT_RR, 1 + 6 * nb);
        add_random(4 + 24 * nb);
      end
      4, 5: add_sdes(1'b0);
      6: begin
        rc = ($urandom_range(15) == 0) ? 31 : $urandom_range(4);
        w  = ($urandom_range(3) == 0) ? $urandom_range(rc) : rc + $urandom_range(2);
        add_header(pick_version(), 1'($urandom_range(1)), 5'(rc), rtcpp_pkg::PT_BYE, w);
        add_random(4 * w);
      end
      7: begin
        do pt = 8'($urandom_range(255));
        while (pt >= rtcpp_pkg::PT_SR && pt <= rtcpp_pkg::PT_BYE);
        if ($urandom_range(1) == 0) pt = PT_APP;
        w = $urandom_range(3);
        add_header(pick_version(), 1'($urandom_range(1)), 5'($urandom_range(31)), pt, w);
        add_random(4 * w);
      end
      default: begin
        // report with a length that does not fit whole blocks
        w = $urandom_range(40);
        if ($urandom_range(1) == 0) begin
          if (w != 0 && w % 6 == 0) w++;
          pt = rtcpp_pkg::PT_SR;
        end else begin
          if (w >= 1 && (w - 1) % 6 == 0) w++;
          pt = rtcpp_pkg::PT_RR;
        end
        add_header(pick_version(), 1'($urandom_range(1)), 5'($urandom_range(31)), pt, w);
        add_random((4 * w > 40) ? 40 : 4 * w);
      end
    endcase
  endfunction

  function automatic void add_random_datagram();
    int unsigned cut;
    if ($urandom_range(19) == 0) begin
      add_random($urandom_range(1, 12));
    end else begin
      repeat ($urandom_range(1, 4)) add_random_packet();
      // end the datagram inside a packet
      if ($urandom_range(5) == 0 && dgram.size() > 1) begin
        cut   = $urandom_range(1, dgram.size() - 1);
        dgram = dgram[0:cut-1];
      end
    end
    send_datagram();
  endfunction

  // Drive input beats from the pending queue and predict each accepted one
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    beat_t nxt;
    logic  offer;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tlast_i  <= 1'b0;
      gap_pct         <= 0;
      stall_pct       <= 0;
      hold_req        <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) parse_byte(s_axis_tdata_i, s_axis_tlast_i);
      offer = beat_q.size() != 0 && !(beat_q[0].drain && want_records.size() != 0) &&
              $urandom_range(99) >= gap_pct;
      if (s_axis_tvalid_i && !s_axis_tready_o) begin
        hold_req <= 1'b0;
      end else if (offer) begin
        nxt = beat_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= nxt.data;
        s_axis_tlast_i  <= nxt.eod;
        gap_pct         <= nxt.gap_pct;
        stall_pct       <= nxt.stall_pct;
        hold_req        <= nxt.hold;
      end else begin
        s_axis_tvalid_i <= 1'b0;
        hold_req        <= 1'b0;
      end
    end
  end

  // Count down a long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Compare each output beat with the oldest predicted record
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    rtcpp_pkg::record_t got;
    rtcpp_pkg::record_t w;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.kind      = m_axis_tuser_o;
        got.pkt_idx   = m_axis_tdata_o[7:0];
        got.item_idx  = m_axis_tdata_o[15:8];
        got.value     = m_axis_tdata_o[47:16];
        got.version   = m_axis_tdata_o[49:48];
        got.padding   = m_axis_tdata_o[50];
        got.rcount    = m_axis_tdata_o[55:51];
        got.ptype     = m_axis_tdata_o[63:56];
        got.sdes_type = m_axis_tdata_o[71:64];
        got.last      = m_axis_tlast_o;
        if (want_records.size() == 0) begin
          if (mismatch_count < SHOW_LIMIT) $display("unexpected record: %s", show_record(got));
          mismatch_count++;
        end else begin
          w = want_records.pop_front();
          if (got !== w) begin
            if (mismatch_count < SHOW_LIMIT)
              $display("record mismatch\n  expected %s\n  actual   %s",
                       show_record(w), show_record(got));
            mismatch_count++;
          end
        end
      end
      m_axis_tready_i <= hold_left == 0 && $urandom_range(99) >= stall_pct;
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned start;
    restart_datagram();

    // Directed datagrams, no idling
    add_header(2'd3, 1'b1, 5'd31, rtcpp_pkg::PT_RR, 1);
    repeat (4) dgram.push_back(8'hFF);
    send_datagram();
    add_header(2'd2, 1'b0, 5'd0, rtcpp_pkg::PT_SR, 0);
    send_datagram();
    add_header(2'd0, 1'b0, 5'd1, rtcpp_pkg::PT_BYE, 1);
    repeat (4) dgram.push_back(8'h00);
    send_datagram();
    add_header(2'd2, 1'b0, 5'd1, rtcpp_pkg::PT_SDES, 2);
    add_random(4);
    dgram.push_back(SDES_END);
    repeat (3) dgram.push_back(8'h00);
    send_datagram();
    dgram.push_back(8'hFF);
    send_datagram();

    // Hold the receiver off while a long receiver report streams in
    mark_hold = 1'b1;
    add_header(2'd2, 1'b0, 5'd6, rtcpp_pkg::PT_RR, 37);
    add_random(148);
    send_datagram();

    start = beat_q.size();
    while (beat_q.size() - start < RANDOM_PER_PHASE) add_random_datagram();

    // Sender idles often; the first datagram of this phase waits for every earlier record
    plan_gap   = 65;
    plan_stall = 0;
    mark_drain = 1'b1;
    start = beat_q.size();
    while (beat_q.size() - start < RANDOM_PER_PHASE) add_random_datagram();

    // Receiver stalls often
    plan_gap   = 0;
    plan_stall = 65;
    start = beat_q.size();
    while (beat_q.size() - start < RANDOM_PER_PHASE) add_random_datagram();

    // Both sides idle now and then
    plan_gap   = 15;
    plan_stall = 15;
    mark_drain = 1'b1;
    start = beat_q.size();
    while (beat_q.size() - start < RANDOM_PER_PHASE) add_random_datagram();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (beat_q.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (want_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
